@@ hdl/tcce_pkg.sv @@
// shared types and constants for the text console cursor engine
package tcce_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int TAB_SH    = $clog2(TAB_WIDTH);

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] ATTR_RST = 8'h07;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_RIGHT  = 3'd1;
  localparam logic [2:0] REG_TOP    = 3'd2;
  localparam logic [2:0] REG_BOTTOM = 3'd3;
  localparam logic [2:0] REG_ATTR   = 3'd4;
  localparam logic [2:0] REG_NLRET  = 3'd5;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_word;
    logic        scrolled;
  } out_item_t;

  // classified command from front to back
  typedef enum logic [2:0] {
    K_NOP, K_READ, K_CLEAR, K_PRINT, K_TAB, K_CR, K_LF, K_BS
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [6:0] rcol;
    logic [4:0] rrow;
  } cmd_t;

  typedef struct packed {
    logic [6:0] l;
    logic [6:0] r;
    logic [4:0] t;
    logic [4:0] b;
    logic [7:0] attr;
    logic       nlret;
  } win_t;

endpackage

@@ hdl/text_console_cursor_engine.sv @@
// top level of the text console cursor engine
//  channel | ports                         | request moves
//  in      | in_push, in_full, in_item     | one operation
//  out     | out_empty, out_pop, out_item  | cursor, cell word, scroll flag
//  cfg     | cfg_psel..cfg_pready          | register write or read
// print, cr, tab, backspace, lf without scroll: S_IDLE, S_OUT; read adds S_RDW
// scroll: S_SCRD/S_SCWR move each window cell up; clear: S_CLR blanks each cell
// a two-entry command queue decouples input from the back end
// after reset every frame store cell is blanked before requests are taken
module text_console_cursor_engine import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  win_t win;
  logic cmd_valid, cmd_take, res_valid, init_busy, q_full;
  cmd_t cmd;

  tcce_regs u_regs (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .win
  );

  tcce_front u_front (
    .clk, .rst_n, .push(in_push && !init_busy), .full(q_full), .item(in_item),
    .cmd_valid, .cmd, .cmd_take
  );
  assign in_full = q_full || init_busy;

  tcce_back u_back (
    .clk, .rst_n, .win, .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res(out_item), .res_take(out_pop), .init_busy
  );
  assign out_empty = !res_valid;
endmodule

@@ hdl/tcce_front.sv @@
// front end: classifies requests into commands and holds a two-entry queue
module tcce_front import tcce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;

  always_comb begin
    c.ch   = item.char_code;
    c.rcol = item.read_col;
    c.rrow = item.read_row;
    case (item.opcode)
      OP_PUT: begin
        case (item.char_code)
          CH_TAB:  c.kind = K_TAB;
          CH_CR:   c.kind = K_CR;
          CH_LF:   c.kind = K_LF;
          CH_BS:   c.kind = K_BS;
          default: c.kind = K_PRINT;
        endcase
      end
      OP_READ:  c.kind = K_READ;
      OP_CLEAR: c.kind = K_CLEAR;
      default:  c.kind = K_NOP;
    endcase
  end

  assign full      = cnt_r == 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];

  wire do_push = push && !full;
  wire do_pop  = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_nopop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !do_pop) else $error("pop from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> cnt_r != 2'd0) else $error("full queue lost entries");
`endif
endmodule

@@ hdl/tcce_back.sv @@
// back end: cursor logic, frame store, scroll and clear sequencer, result register
module tcce_back import tcce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  win_t      win,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_take,
  output logic      init_busy
);
  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDW   = 7'b0000100,
    S_SCRD  = 7'b0001000,
    S_SCWR  = 7'b0010000,
    S_CLR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  logic [15:0] mem [CELLS];
  logic [15:0] rd_r;
  st_t  st_r, st_nxt;
  logic [6:0] col_r, col_nxt, x_r, x_nxt;
  logic [4:0] row_r, row_nxt, y_r, y_nxt;
  logic [AW-1:0] ia_r, ia_nxt;
  logic [15:0] word_r;
  logic        scr_r;
  logic        ld_word, set_scr, clr_scr;
  cmd_t        c_r;
  logic        we, re;
  logic [AW-1:0] wa, ra;
  logic [15:0] wd;
  logic        res_v_r;
  out_item_t   res_r;

  // effective window
  logic [6:0] er, el;
  logic [4:0] eb, et;
  always_comb begin
    er = (win.r > 7'(COLUMNS-1)) ? 7'(COLUMNS-1) : win.r;
    el = (win.l > er) ? er : win.l;
    eb = (win.b > 5'(ROWS-1)) ? 5'(ROWS-1) : win.b;
    et = (win.t > eb) ? eb : win.t;
  end

  function automatic logic [AW-1:0] addr(input logic [6:0] x, input logic [4:0] y);
    addr = AW'(y) * AW'(COLUMNS) + AW'(x);
  endfunction

  logic [8:0] tabx;
  logic [7:0] inc;
  assign tabx = ((9'(col_r) + 9'(2*TAB_WIDTH-1)) >> TAB_SH) << TAB_SH;
  assign inc  = 8'(col_r) + 8'd1;
  wire in_frame = (col_r < 7'(COLUMNS)) && (row_r < 5'(ROWS));
  wire [15:0] attr_w = {win.attr, 8'h00};

  // line advance outcome
  wire at_bot = row_r == eb;
  wire [4:0] row_adv = (row_r < 5'(ROWS-1)) ? row_r + 5'd1 : row_r;

  always_comb begin
    st_nxt = st_r; col_nxt = col_r; row_nxt = row_r;
    x_nxt = x_r; y_nxt = y_r; ia_nxt = ia_r;
    we = 1'b0; wa = addr(col_r, row_r); wd = 16'h0;
    re = 1'b0; ra = addr(x_r, y_r);
    cmd_take = 1'b0; ld_word = 1'b0; set_scr = 1'b0; clr_scr = 1'b0;
    case (st_r)
      S_INIT: begin
        we = 1'b1; wa = ia_r; wd = {ATTR_RST, CH_SP};
        ia_nxt = ia_r + AW'(1);
        if (ia_r == AW'(CELLS-1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid && !res_v_r) begin
          cmd_take = 1'b1; clr_scr = 1'b1;
          st_nxt = S_OUT;
          case (cmd.kind)
            K_READ: begin
              re = 1'b1; ra = addr(cmd.rcol, cmd.rrow);
              st_nxt = S_RDW;
            end
            K_CLEAR: begin
              x_nxt = el; y_nxt = et; st_nxt = S_CLR;
            end
            K_CR: col_nxt = el;
            K_TAB: begin
              if (tabx > 9'(er)) begin
                col_nxt = el;
                if (at_bot) begin
                  x_nxt = el; y_nxt = et; st_nxt = S_SCRD; set_scr = 1'b1;
                end else row_nxt = row_adv;
              end else col_nxt = tabx[6:0];
            end
            K_LF: begin
              if (win.nlret) col_nxt = el;
              if (at_bot) begin
                x_nxt = el; y_nxt = et; st_nxt = S_SCRD; set_scr = 1'b1;
              end else row_nxt = row_adv;
            end
            K_BS: begin
              if (col_r > el) begin
                col_nxt = col_r - 7'd1;
                we = (col_nxt < 7'(COLUMNS)) && (row_r < 5'(ROWS));
                wa = addr(col_nxt, row_r); wd = {win.attr, CH_SP};
              end
            end
            K_PRINT: begin
              we = in_frame; wd = {win.attr, cmd.ch};
              if (inc > 8'(er)) begin
                col_nxt = el;
                if (at_bot) begin
                  x_nxt = el; y_nxt = et; st_nxt = S_SCRD; set_scr = 1'b1;
                end else row_nxt = row_adv;
              end else col_nxt = inc[6:0];
            end
            default: ;
          endcase
        end
      end
      S_RDW: begin
        ld_word = 1'b1; st_nxt = S_OUT;
      end
      S_SCRD: begin
        // read the cell below, or fill the bottom row
        if (y_r == eb) begin
          we = 1'b1; wa = addr(x_r, y_r); wd = attr_w;
          if (x_r == er) st_nxt = S_OUT;
          else x_nxt = x_r + 7'd1;
        end else begin
          re = 1'b1; ra = addr(x_r, y_r + 5'd1); st_nxt = S_SCWR;
        end
      end
      S_SCWR: begin
        we = 1'b1; wa = addr(x_r, y_r); wd = rd_r;
        st_nxt = S_SCRD;
        if (x_r == er) begin
          x_nxt = el; y_nxt = y_r + 5'd1;
        end else x_nxt = x_r + 7'd1;
      end
      S_CLR: begin
        we = 1'b1; wa = addr(x_r, y_r); wd = {win.attr, CH_SP};
        if (x_r == er) begin
          x_nxt = el;
          if (y_r == eb) begin
            st_nxt = S_OUT; col_nxt = el; row_nxt = et;
          end else y_nxt = y_r + 5'd1;
        end else x_nxt = x_r + 7'd1;
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd_take) c_r <= cmd;
    if (!rst_n) begin
      st_r <= S_INIT; col_r <= 7'd0; row_r <= 5'd0; ia_r <= '0;
      x_r <= 7'd0; y_r <= 5'd0; res_v_r <= 1'b0; word_r <= 16'h0; scr_r <= 1'b0;
    end else begin
      st_r <= st_nxt; col_r <= col_nxt; row_r <= row_nxt; ia_r <= ia_nxt;
      x_r <= x_nxt; y_r <= y_nxt;
      if (clr_scr) begin
        word_r <= 16'h0; scr_r <= set_scr;
      end
      if (ld_word)
        word_r <= (c_r.rcol < 7'(COLUMNS) && c_r.rrow < 5'(ROWS)) ? rd_r : 16'h0;
      if (st_r == S_OUT) res_v_r <= 1'b1;
      else if (res_take) res_v_r <= 1'b0;
    end
  end

  always_comb begin
    res_r.cursor_col = col_r;
    res_r.cursor_row = row_r;
    res_r.cell_word  = word_r;
    res_r.scrolled   = scr_r;
  end

  assign res       = res_r;
  assign res_valid = res_v_r;
  assign init_busy = st_r == S_INIT;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> st_r == S_IDLE && !res_v_r) else $error("command taken while busy");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_OUT |=> res_v_r) else $error("result not posted");
`endif
endmodule

@@ hdl/tcce_regs.sv @@
// configuration registers behind the apb port
module tcce_regs import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output win_t        win
);
  win_t w_r;
  wire [2:0] idx = paddr[4:2];
  assign pready = 1'b1;
  assign win = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.l <= 7'd0; w_r.r <= 7'(COLUMNS-1); w_r.t <= 5'd0; w_r.b <= 5'(ROWS-1);
      w_r.attr <= ATTR_RST; w_r.nlret <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_LEFT:   w_r.l <= pwdata[6:0];
        REG_RIGHT:  w_r.r <= pwdata[6:0];
        REG_TOP:    w_r.t <= pwdata[4:0];
        REG_BOTTOM: w_r.b <= pwdata[4:0];
        REG_ATTR:   w_r.attr <= pwdata[7:0];
        REG_NLRET:  w_r.nlret <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEFT:   prdata = {25'd0, w_r.l};
      REG_RIGHT:  prdata = {25'd0, w_r.r};
      REG_TOP:    prdata = {27'd0, w_r.t};
      REG_BOTTOM: prdata = {27'd0, w_r.b};
      REG_ATTR:   prdata = {24'd0, w_r.attr};
      REG_NLRET:  prdata = {31'd0, w_r.nlret};
      default:    prdata = 32'd0;
    endcase
  end
endmodule
